FILE: rtl/core/local_covariance_accumulator_macros.svh
// Assertion macros for the local covariance accumulator.
// No dependencies; included by the modules that carry assertions.
`ifndef LOCAL_COVARIANCE_ACCUMULATOR_MACROS_SVH
`define LOCAL_COVARIANCE_ACCUMULATOR_MACROS_SVH
// implication checked on every edge outside reset
`define LCA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// next-cycle implication
`define LCA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

FILE: rtl/core/lca_pkg.sv
// Shared types and constants of the local covariance accumulator.
// No dependencies.
package lca_pkg;
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_KERN  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [1:0] REG_DIFF  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_DIM   = 2'd2;

    localparam int CFG_W = 11;

    typedef struct packed {
        logic [1:0]  mode;
        logic [9:0]  sample_row;
        logic [2:0]  sample_col;
        logic signed [15:0] sample_value;
        logic signed [15:0] weight;
        logic [9:0]  first_index;
        logic [9:0]  second_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  out_row;
        logic [2:0]  out_col;
        logic signed [63:0] value;
        logic        last;
    } out_item_t;

    // command handed from front to back part
    typedef struct packed {
        logic [1:0]  mode;
        logic signed [15:0] weight;
        logic [9:0]  first_index;
        logic [9:0]  second_index;
    } cmd_t;
endpackage

FILE: rtl/core/lca_if.sv
// Valid/ready channel interface carrying one payload struct.
// Depends on lca_pkg only through the type parameter given by users.
interface lca_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/lca_front.sv
// Front part: accepts items, writes in-range samples, queues other commands; drops out-of-range kernel entries.
// Depends on lca_pkg and lca_if.
module lca_front #(
    parameter int MAX_SAMPLES = 1024,
    parameter int DIM = 8,
    parameter int SW = 13
) (
    input  logic clk,
    input  logic rst_n,
    lca_if.sink  in_ch,
    output logic                    st_we,
    output logic [SW-1:0]           st_waddr,
    output logic signed [15:0]      st_wdata,
    output logic                    q_valid,
    output lca_pkg::cmd_t           q_data,
    input  logic                    q_ready
);
    import lca_pkg::*;
    localparam int RW = $clog2(MAX_SAMPLES);
    localparam int CW = (DIM > 1) ? $clog2(DIM) : 1;

    // two-entry command queue
    cmd_t       q_mem_reg [2];
    logic       wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       acc, push, pop, in_range, load_in;

    // hold a sample load until no command is in flight, so it never
    // overtakes the row fetch of an earlier kernel entry
    assign load_in = (in_ch.data.mode == MODE_LOAD);
    assign in_ch.ready = (cnt_reg != 2'd2) && !(load_in && ((cnt_reg != 2'd0) || !q_ready));
    assign acc = in_ch.valid && in_ch.ready;
    assign in_range = (32'(in_ch.data.sample_row) < MAX_SAMPLES)
                   && (32'(in_ch.data.sample_col) < DIM);
    assign st_we    = acc && load_in && in_range;
    assign st_waddr = SW'(32'(in_ch.data.sample_row[RW-1:0]) * DIM
                      + 32'(in_ch.data.sample_col[CW-1:0]));
    assign st_wdata = in_ch.data.sample_value;
    assign push = acc && !load_in
                  && !((in_ch.data.mode == MODE_KERN)
                       && ((32'(in_ch.data.first_index) >= MAX_SAMPLES)
                        || (32'(in_ch.data.second_index) >= MAX_SAMPLES)));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_mem_reg[rp_reg];
    assign pop = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wp_reg] <= '{mode: in_ch.data.mode, weight: in_ch.data.weight,
                                   first_index: in_ch.data.first_index,
                                   second_index: in_ch.data.second_index};
        end
    end
endmodule

FILE: rtl/core/lca_back.sv
// Back part: sample store, row fetch, shared multiply-accumulate, readout divider.
// Depends on lca_pkg, lca_if and the assertion macro header.
`include "local_covariance_accumulator_macros.svh"
module lca_back #(
    parameter int MAX_SAMPLES = 1024,
    parameter int DIM = 8,
    parameter int SW = 13
) (
    input  logic clk,
    input  logic rst_n,
    input  logic                    st_we,
    input  logic [SW-1:0]           st_waddr,
    input  logic signed [15:0]      st_wdata,
    input  logic                    q_valid,
    input  lca_pkg::cmd_t           q_data,
    output logic                    q_ready,
    input  logic                    diff_mode,
    input  logic [10:0]             sample_count,
    input  logic [3:0]              dim_in_use,
    lca_if.source out_ch
);
    import lca_pkg::*;
    localparam int RW = $clog2(MAX_SAMPLES);
    localparam int CW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int EW = (DIM > 1) ? 2 * CW : 1;
    localparam int NA = DIM * DIM;
    localparam int DW = $clog2(DIM + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_CLR   = 3'd5;

    // divider steps: 0 read, 1 load, 2..64 one quotient bit each, 65 wait
    localparam logic [6:0] DIV_LOAD = 7'd1;
    localparam logic [6:0] DIV_END  = 7'd65;

    logic signed [15:0] store_mem [MAX_SAMPLES * DIM];
    logic signed [15:0] rd_data_reg;
    logic [SW-1:0]      rd_addr;
    logic signed [63:0] acc_mem [NA];
    logic signed [63:0] acc_rd_reg;
    logic [EW-1:0]      acc_raddr;
    logic [NA-1:0]      acc_ok_reg;
    logic signed [16:0] a_reg [DIM];
    logic signed [16:0] b_reg [DIM];

    logic [2:0]  st_reg, st_next;
    cmd_t        cmd_reg;
    logic [CW:0] ri_reg, ci_reg;      // row/col counters
    logic [CW:0] fi_reg;              // fetch index
    logic [1:0]  fph_reg;             // fetch phase
    logic [DW-1:0] d_eff;
    logic [6:0]  dstep_reg;
    logic        mvalid_reg;
    logic signed [33:0] wa_reg;
    logic signed [63:0] prod_reg;
    logic [EW-1:0] pidx_reg;
    logic        pvalid_reg;
    logic [63:0] rem_reg, quo_reg;
    logic        neg_reg;
    logic [10:0] div_reg;
    logic [EW-1:0] eidx;
    logic [CW-1:0] ri_s, ci_s;
    out_item_t   obuf_reg;
    logic        ovalid_reg;
    logic [63:0] quo_fin;
    logic signed [16:0] bsel_d;
    logic [EW-1:0]      pidx_q;

    assign ri_s = ri_reg[CW-1:0];
    assign ci_s = ci_reg[CW-1:0];
    assign eidx = EW'(32'(ri_s) * DIM + 32'(ci_s));
    assign d_eff = (dim_in_use == 4'd0) ? DW'(1)
                 : ((32'(dim_in_use) > DIM) ? DW'(DIM) : DW'(dim_in_use));

    // fetch: phase 0 reads first row element, phase 1 the second
    always_comb
    begin
        if (fph_reg[0] == 1'b0)
            rd_addr = SW'(32'(cmd_reg.first_index[RW-1:0]) * DIM + 32'(fi_reg[CW-1:0]));
        else
            rd_addr = SW'(32'(cmd_reg.second_index[RW-1:0]) * DIM + 32'(fi_reg[CW-1:0]));
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= st_wdata;
        rd_data_reg <= store_mem[rd_addr];
    end

    assign q_ready = (st_reg == S_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = obuf_reg;

    logic last_el;
    assign last_el = (ri_reg == (CW+1)'(d_eff - 1'b1)) && (ci_reg == (CW+1)'(d_eff - 1'b1));

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_data.mode)
                        MODE_KERN:  st_next = S_FETCH;
                        MODE_READ:  st_next = S_DIV;
                        MODE_CLEAR: st_next = S_CLR;
                        default:    st_next = S_IDLE;
                    endcase
                end
            end
            S_FETCH: if (fph_reg == 2'd2 && fi_reg == (CW+1)'(d_eff)) st_next = S_MAC;
            S_MAC:   if (!mvalid_reg && !pvalid_reg && ri_reg == (CW+1)'(d_eff))
                         st_next = S_IDLE;
            S_DIV:   if (dstep_reg == DIV_END && !ovalid_reg) st_next = S_EMIT;
            S_EMIT:  if (!ovalid_reg) st_next = last_el ? S_IDLE : S_DIV;
            S_CLR:   st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    logic signed [16:0] rd_ext;
    assign rd_ext = {rd_data_reg[15], rd_data_reg};

    // accumulator read port: product pipeline during MAC, readout element otherwise
    assign acc_raddr = (st_reg == S_MAC) ? pidx_reg : eidx;

    logic signed [63:0] acc_cur, sum;
    logic signed [64:0] sum_w;
    assign acc_cur = acc_ok_reg[pidx_q] ? acc_rd_reg : 64'sd0;
    assign sum_w = {acc_cur[63], acc_cur} + {prod_reg[63], prod_reg};
    always_comb
    begin
        if (sum_w[64] != sum_w[63])
            sum = sum_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            sum = sum_w[63:0];
    end

    logic [64:0] trial;
    assign trial = {rem_reg, quo_reg[63]} - {54'd0, div_reg};

    // one more step finishes the division on entry to emit
    assign quo_fin = trial[64] ? {quo_reg[62:0], 1'b0} : {quo_reg[62:0], 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            acc_ok_reg <= '0;
            ovalid_reg <= 1'b0;
            mvalid_reg <= 1'b0;
            pvalid_reg <= 1'b0;
            ri_reg <= '0; ci_reg <= '0; fi_reg <= '0; fph_reg <= '0; dstep_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (ovalid_reg && out_ch.ready)
                ovalid_reg <= 1'b0;
            pvalid_reg <= mvalid_reg;
            mvalid_reg <= (st_reg == S_MAC) && (ri_reg != (CW+1)'(d_eff));
            if (st_reg == S_CLR)
                acc_ok_reg <= '0;
            else if (pvalid_reg)
                acc_ok_reg[pidx_q] <= 1'b1;
            unique case (st_reg)
                S_IDLE:
                begin
                    ri_reg <= '0; ci_reg <= '0; fi_reg <= '0; fph_reg <= '0;
                    dstep_reg <= '0;
                end
                S_FETCH:
                begin
                    // phase 0 issue first, 1 issue second/latch first, 2 latch second
                    if (fph_reg == 2'd0)
                        fph_reg <= 2'd1;
                    else if (fph_reg == 2'd1)
                    begin
                        if (fi_reg != (CW+1)'(d_eff))
                            a_reg[fi_reg[CW-1:0]] <= rd_ext;
                        fph_reg <= 2'd2;
                    end
                    else if (fi_reg != (CW+1)'(d_eff))
                    begin
                        b_reg[fi_reg[CW-1:0]] <= rd_ext;
                        if (diff_mode)
                            a_reg[fi_reg[CW-1:0]] <= a_reg[fi_reg[CW-1:0]] - rd_ext;
                        fi_reg  <= fi_reg + 1'b1;
                        fph_reg <= 2'd0;
                    end
                end
                S_MAC:
                begin
                    if (ri_reg != (CW+1)'(d_eff))
                    begin
                        if (ci_reg == (CW+1)'(d_eff - 1'b1))
                        begin
                            ci_reg <= '0;
                            ri_reg <= ri_reg + 1'b1;
                        end
                        else
                            ci_reg <= ci_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (dstep_reg != DIV_END)
                        dstep_reg <= dstep_reg + 1'b1;
                end
                S_EMIT:
                begin
                    if (!ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        dstep_reg  <= '0;
                        if (ci_reg == (CW+1)'(d_eff - 1'b1))
                        begin
                            ci_reg <= '0;
                            ri_reg <= ri_reg + 1'b1;
                        end
                        else
                            ci_reg <= ci_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset
    logic signed [16:0] bsel;
    logic signed [63:0] acur_div;
    assign acur_div = acc_ok_reg[eidx] ? acc_rd_reg : 64'sd0;
    always_comb
    begin
        bsel = diff_mode ? a_reg[ci_s] : b_reg[ci_s];
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && q_valid)
            cmd_reg <= q_data;
        acc_rd_reg <= acc_mem[acc_raddr];
        // stage 1: weight times row element
        if (st_reg == S_MAC && ri_reg != (CW+1)'(d_eff))
        begin
            wa_reg   <= 34'(cmd_reg.weight) * 34'(a_reg[ri_s]);
            pidx_reg <= eidx;
        end
        // stage 2: times column element, times four
        if (mvalid_reg)
            prod_reg <= (64'(wa_reg) * 64'(bsel_d)) <<< 2;
        if (pvalid_reg)
            acc_mem[pidx_q] <= sum;
        // restoring divide, one quotient bit per cycle
        if (st_reg == S_DIV)
        begin
            if (dstep_reg == DIV_LOAD)
            begin
                neg_reg <= acur_div[63];
                div_reg <= (sample_count == 11'd0) ? 11'd1 : sample_count;
                rem_reg <= '0;
                quo_reg <= acur_div[63] ? 64'(-acur_div) : 64'(acur_div);
            end
            else if (dstep_reg > DIV_LOAD && dstep_reg != DIV_END)
            begin
                if (!trial[64])
                begin
                    rem_reg <= trial[63:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[62:0], quo_reg[63]};
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
            end
        end
        if (st_reg == S_EMIT && !ovalid_reg)
        begin
            obuf_reg.out_row <= 3'(ri_s);
            obuf_reg.out_col <= 3'(ci_s);
            obuf_reg.value   <= neg_reg ? -$signed(quo_fin) : $signed(quo_fin);
            obuf_reg.last    <= last_el;
        end
    end

    // column operand and index delayed to line up with the product stage
    always_ff @(posedge clk)
    begin
        bsel_d <= bsel;
        pidx_q <= pidx_reg;
    end

    `LCA_ASSERT_NXT(a_out_hold, ovalid_reg && !out_ch.ready, ovalid_reg && $stable(obuf_reg))
    `LCA_ASSERT_IMP(a_qready, q_ready, st_reg == S_IDLE)
    `LCA_ASSERT_NXT(a_clr, st_reg == S_CLR, acc_ok_reg == '0)
endmodule

FILE: rtl/core/local_covariance_accumulator.sv
// Local covariance accumulator: sample store plus DIM x DIM weighted
// outer-product accumulator. Depends on lca_pkg, lca_if, lca_front, lca_back.
//
// Usage: items arrive on in_ch (valid/ready). Mode 0 writes one sample into
// the store (no result). Mode 1 adds four times weight times the outer product
// of two rows (or of their difference) to the matrix. Mode 2 reads out every
// element in use, row by row, divided by sample_count, with last on the final
// one. Mode 3 clears the matrix. Results leave on out_ch (valid/ready).
// A command leaves the queue when the back part is idle. A kernel entry
// then fetches its rows through the single store read port and runs
// through the shared multiply-accumulate unit. A readout element passes
// through the bit-serial divider and is then emitted.
// A two-entry command queue holds commands while the back part works; a
// sample load waits until no command is in flight.
// Reset clears the matrix (valid bits), the queue and the control registers; the
// sample store is undefined until written. When the receiver stalls the
// output register holds the element and the back part waits.
module local_covariance_accumulator #(
    parameter int MAX_SAMPLES = 1024,
    parameter int DIM = 8
) (
    input  logic clk,
    input  logic rst_n,
    lca_if.sink   in_ch,
    lca_if.source out_ch,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [lca_pkg::CFG_W-1:0] cfg_data
);
    import lca_pkg::*;
    localparam int SW = $clog2(MAX_SAMPLES * DIM);

    logic diff_mode_reg;
    logic [10:0] sample_count_reg;
    logic [3:0]  dim_in_use_reg;
    logic st_we, q_valid, q_ready;
    logic [SW-1:0] st_waddr;
    logic signed [15:0] st_wdata;
    cmd_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_mode_reg    <= 1'b0;
            sample_count_reg <= 11'd1024;
            dim_in_use_reg   <= 4'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIFF:  diff_mode_reg    <= cfg_data[0];
                REG_COUNT: sample_count_reg <= cfg_data[10:0];
                REG_DIM:   dim_in_use_reg   <= cfg_data[3:0];
                default:   ;
            endcase
        end
    end

    lca_front #(.MAX_SAMPLES(MAX_SAMPLES), .DIM(DIM), .SW(SW)) u_front (
        .clk, .rst_n, .in_ch, .st_we, .st_waddr, .st_wdata,
        .q_valid, .q_data, .q_ready);

    lca_back #(.MAX_SAMPLES(MAX_SAMPLES), .DIM(DIM), .SW(SW)) u_back (
        .clk, .rst_n, .st_we, .st_waddr, .st_wdata, .q_valid, .q_data, .q_ready,
        .diff_mode(diff_mode_reg), .sample_count(sample_count_reg),
        .dim_in_use(dim_in_use_reg), .out_ch);
endmodule
